/* hw/rtl/zlru_pkg.sv */
package zlru_pkg;

   // Command codes carried on the request side.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_EVICT = 2'd2;

   // Register indexes of the configuration port.
   localparam logic REG_CHUNKS_PER_ZONE = 1'b0;

   localparam int          CHUNKS_W         = 17;
   localparam logic [16:0] CHUNKS_PER_ZONE_RESET = 17'd65536;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  zone;
      logic [15:0] chunk_pos;
   } zlru_item_type;

   typedef struct packed {
      logic       evicted;
      logic [7:0] victim_zone;
      logic [8:0] occupancy;
   } zlru_result_type;

endpackage

/* hw/rtl/zone_lru_eviction_policy.sv */
// Channel    Direction  Handshake                 Payload
// req_       in         req_tvalid / req_tready   tuser cmd, tdata zone + chunk_pos
// rsp_       out        rsp_tvalid / rsp_tready   tuser evicted, tdata victim_zone + occupancy
// csr_       in         APB psel/penable/pready   chunks_per_zone at byte address 0
//
// Every request yields exactly one response. After its transfer a request passes
// through these steps before the next request can be taken: read both link
// memories, unlink the zone, append it, then hand the result to the output
// register. Reset clears the presence bits, head, tail and count at once, so no
// clearing pass is needed. A stalled response holds the sequencer in its last
// step until the output register frees up.
module zone_lru_eviction_policy
   import zlru_pkg::*;
#(
   parameter int NUM_ZONES = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic [23:0] req_tdata,   // zone[7:0], chunk_pos[23:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // evicted[0]
   output logic [23:0] rsp_tdata,   // victim_zone[7:0], occupancy[16:8], zero[23:17]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [CHUNKS_W-1:0] chunks_per_zone;
   zlru_item_type       item;
   zlru_result_type     res;
   logic                res_valid;
   logic                res_ready;

   logic                rsp_valid_ff, rsp_valid_in;
   zlru_result_type     rsp_data_ff, rsp_data_in;

   zlru_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata),
      .pready          (csr_pready),
      .chunks_per_zone (chunks_per_zone)
   );

   assign item.cmd       = req_tuser;
   assign item.zone      = req_tdata[7:0];
   assign item.chunk_pos = req_tdata[23:8];

   // The linked list engine owns the two link memories and the list pointers.
   zlru_list #(
      .NUM_ZONES (NUM_ZONES)
   ) u_list (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (req_tvalid),
      .item_ready      (req_tready),
      .item            (item),
      .chunks_per_zone (chunks_per_zone),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res)
   );

   // The output register takes a new result whenever it is empty or its
   // current result is being transferred in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.evicted;
   assign rsp_tdata  = {7'd0, rsp_data_ff.occupancy, rsp_data_ff.victim_zone};

endmodule

/* hw/rtl/zlru_csr.sv */
module zlru_csr
   import zlru_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output logic [CHUNKS_W-1:0] chunks_per_zone
);

   logic [CHUNKS_W-1:0] chunks_ff;
   logic [CHUNKS_W-1:0] chunks_in;
   logic                wr_hit;

   // The register index is the word address; only index zero exists.
   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CHUNKS_PER_ZONE);

   always_comb begin
      chunks_in = chunks_ff;
      if (wr_hit) begin
         chunks_in = pwdata[CHUNKS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunks_ff <= CHUNKS_PER_ZONE_RESET;
      end else begin
         chunks_ff <= chunks_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == REG_CHUNKS_PER_ZONE) begin
         prdata = {{(32 - CHUNKS_W){1'b0}}, chunks_ff};
      end
   end

   assign chunks_per_zone = chunks_ff;

endmodule

/* hw/rtl/zlru_list.sv */
module zlru_list
   import zlru_pkg::*;
#(
   parameter int NUM_ZONES = 256
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  zlru_item_type       item,
   input  logic [CHUNKS_W-1:0] chunks_per_zone,
   output logic                res_valid,
   input  logic                res_ready,
   output zlru_result_type     res
);

   // Only zones below 256 can be addressed by the 8-bit zone field.
   localparam int ZONE_SLOTS = (NUM_ZONES < 256) ? NUM_ZONES : 256;
   localparam int IDX_W      = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
   localparam int LINK_W     = $clog2(NUM_ZONES + 1);
   localparam int CNT_W      = $clog2(ZONE_SLOTS + 1);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_ZONES);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_UNLINK = 2'd1;
   localparam logic [1:0] S_APPEND = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [LINK_W-1:0] next_mem [ZONE_SLOTS];
   logic [LINK_W-1:0] prev_mem [ZONE_SLOTS];

   logic [1:0]            state_ff, state_in;
   logic [ZONE_SLOTS-1:0] present_ff, present_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [LINK_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      target_ff, target_in;
   logic                  unlink_ff, unlink_in;
   logic                  append_ff, append_in;
   logic                  evict_ff, evict_in;
   logic [LINK_W-1:0]     next_rd_ff, prev_rd_ff;

   logic              accept;
   logic              in_range;
   logic [IDX_W-1:0]  zone_idx;
   logic              zone_present;
   logic              fills;
   logic              evict_ok;
   logic [CHUNKS_W-1:0] last_chunk;
   logic [IDX_W-1:0]  rd_addr;
   logic [LINK_W-1:0] p_link, n_link;

   logic              nx_we, pv_we;
   logic [IDX_W-1:0]  nx_waddr, pv_waddr;
   logic [LINK_W-1:0] nx_wdata, pv_wdata;

   assign accept       = (state_ff == S_IDLE) && item_valid;
   assign in_range     = (32'(item.zone) < NUM_ZONES);
   assign zone_idx     = item.zone[IDX_W-1:0];
   assign zone_present = in_range && present_ff[zone_idx];
   assign last_chunk   = chunks_per_zone - CHUNKS_W'(1);
   assign fills        = in_range && ({1'b0, item.chunk_pos} == last_chunk);
   assign evict_ok     = (count_ff != '0) && (head_ff != NULL_LINK);
   assign rd_addr      = (item.cmd == CMD_EVICT) ? head_ff[IDX_W-1:0] : zone_idx;

   // The end links are implied by head and tail, so the next link of the new
   // tail never has to be written during an append.
   assign p_link = (LINK_W'(target_ff) == head_ff) ? NULL_LINK : prev_rd_ff;
   assign n_link = (LINK_W'(target_ff) == tail_ff) ? NULL_LINK : next_rd_ff;

   always_comb begin
      state_in   = state_ff;
      present_in = present_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      target_in  = target_ff;
      unlink_in  = unlink_ff;
      append_in  = append_ff;
      evict_in   = evict_ff;
      nx_we      = 1'b0;
      nx_waddr   = target_ff;
      nx_wdata   = NULL_LINK;
      pv_we      = 1'b0;
      pv_waddr   = target_ff;
      pv_wdata   = NULL_LINK;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               target_in = rd_addr;
               evict_in  = (item.cmd == CMD_EVICT) && evict_ok;
               unlink_in = ((item.cmd == CMD_READ) && zone_present)
                        || ((item.cmd == CMD_WRITE) && fills && zone_present)
                        || ((item.cmd == CMD_EVICT) && evict_ok);
               append_in = ((item.cmd == CMD_READ) && zone_present)
                        || ((item.cmd == CMD_WRITE) && fills);
               state_in  = S_UNLINK;
            end
         end
         S_UNLINK: begin
            if (unlink_ff) begin
               present_in[target_ff] = 1'b0;
               count_in              = count_ff - CNT_W'(1);
               if (p_link != NULL_LINK) begin
                  nx_we    = 1'b1;
                  nx_waddr = p_link[IDX_W-1:0];
                  nx_wdata = n_link;
               end else begin
                  head_in = n_link;
               end
               if (n_link != NULL_LINK) begin
                  pv_we    = 1'b1;
                  pv_waddr = n_link[IDX_W-1:0];
                  pv_wdata = p_link;
               end else begin
                  tail_in = p_link;
               end
            end
            state_in = S_APPEND;
         end
         S_APPEND: begin
            if (append_ff) begin
               present_in[target_ff] = 1'b1;
               count_in              = count_ff + CNT_W'(1);
               pv_we                 = 1'b1;
               pv_waddr              = target_ff;
               pv_wdata              = tail_ff;
               if (tail_ff != NULL_LINK) begin
                  nx_we    = 1'b1;
                  nx_waddr = tail_ff[IDX_W-1:0];
                  nx_wdata = LINK_W'(target_ff);
               end else begin
                  head_in = LINK_W'(target_ff);
               end
               tail_in = LINK_W'(target_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         present_ff <= '0;
         head_ff    <= NULL_LINK;
         tail_ff    <= NULL_LINK;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      unlink_ff <= unlink_in;
      append_ff <= append_in;
      evict_ff  <= evict_in;
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_waddr] <= nx_wdata;
      end
      if (accept) begin
         next_rd_ff <= next_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pv_we) begin
         prev_mem[pv_waddr] <= pv_wdata;
      end
      if (accept) begin
         prev_rd_ff <= prev_mem[rd_addr];
      end
   end

   assign item_ready      = (state_ff == S_IDLE);
   assign res_valid       = (state_ff == S_DONE);
   assign res.evicted     = evict_ff;
   assign res.victim_zone = evict_ff ? 8'(target_ff) : 8'd0;
   assign res.occupancy   = 9'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= ZONE_SLOTS)
      else $error("zone count exceeds the number of zones");

   a_head_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((count_ff == '0) == (head_ff == NULL_LINK)))
      else $error("head pointer disagrees with zone count");

   a_tail_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((count_ff == '0) == (tail_ff == NULL_LINK)))
      else $error("tail pointer disagrees with zone count");

   a_unlink_present: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_UNLINK) && unlink_ff) |-> present_ff[target_ff])
      else $error("unlink of a zone that is not in the order");

endmodule
